### sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the greedy box suppression block: widths of
// the fixed result fields, the threshold register and the compare status.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int THR_W       = 16;
   localparam int ITEM_W      = 16;
   localparam int SLOT_W      = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [THR_W-1:0]  THR_RESET = 16'd29491;
   localparam logic [ITEM_W-1:0] ITEM_MAX  = 16'hFFFF;

   // register index taken from the word address bit of paddr
   localparam logic CSR_IDX_THR = 1'b0;

   // status of the overlap compare pipeline
   typedef struct packed {
      logic busy;
      logic hit;
   } cmp_status_type;

endpackage

### sv/gbn_kept_store.sv
// ----------------------------------------------------------------------------
// gbn_kept_store
// Kept box store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gbn_kept_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/gbn_iou_pipe.sv
// ----------------------------------------------------------------------------
// gbn_iou_pipe
// Six stage overlap compare: intersection, areas, union and the
// division-free test inter * 2^16 > threshold * union, one kept box a cycle.
// ----------------------------------------------------------------------------
module gbn_iou_pipe #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [4*COORD_BITS-1:0]      cur_box,
   input  logic [4*COORD_BITS-1:0]      kept_box,
   input  logic [gbn_pkg::THR_W-1:0]    thr,
   output gbn_pkg::cmp_status_type      status
);

   localparam int C      = COORD_BITS;
   localparam int E_W    = C + 2;
   localparam int AREA_W = 2 * C;
   localparam int UNI_W  = AREA_W + 1;
   localparam int PROD_W = UNI_W + gbn_pkg::THR_W;

   logic signed [C-1:0] a_left, a_top, b_left, b_top;
   logic        [C-1:0] a_w, a_h, b_w, b_h;
   logic signed [E_W-1:0] a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1;

   // stage 1
   logic                  v1_ff;
   logic signed [E_W-1:0] lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff;
   logic signed [E_W-1:0] lo_x_in, hi_x_in, lo_y_in, hi_y_in;
   logic        [C-1:0]   aw1_ff, ah1_ff, bw1_ff, bh1_ff;
   // stage 2
   logic                  v2_ff;
   logic signed [E_W-1:0] dx, dy;
   logic        [C-1:0]   iw_in, ih_in, iw_ff, ih_ff;
   logic        [C-1:0]   aw2_ff, ah2_ff, bw2_ff, bh2_ff;
   // stage 3
   logic                  v3_ff;
   logic [AREA_W-1:0]     inter3_ff, area_a_ff, area_b_ff;
   // stage 4
   logic                  v4_ff;
   logic [UNI_W-1:0]      uni_ff;
   logic [AREA_W-1:0]     inter4_ff;
   // stage 5
   logic                  v5_ff;
   logic [PROD_W-1:0]     prod_ff, shift_ff;
   // stage 6
   logic                  v6_ff;
   logic                  hit_ff;

   always_comb begin
      a_left = cur_box[4*C-1:3*C];
      a_top  = cur_box[3*C-1:2*C];
      a_w    = cur_box[2*C-1:C];
      a_h    = cur_box[C-1:0];
      b_left = kept_box[4*C-1:3*C];
      b_top  = kept_box[3*C-1:2*C];
      b_w    = kept_box[2*C-1:C];
      b_h    = kept_box[C-1:0];

      a_x0 = E_W'(a_left);
      a_y0 = E_W'(a_top);
      b_x0 = E_W'(b_left);
      b_y0 = E_W'(b_top);
      a_x1 = a_x0 + signed'({2'b00, a_w});
      a_y1 = a_y0 + signed'({2'b00, a_h});
      b_x1 = b_x0 + signed'({2'b00, b_w});
      b_y1 = b_y0 + signed'({2'b00, b_h});

      lo_x_in = (a_x0 > b_x0) ? a_x0 : b_x0;
      lo_y_in = (a_y0 > b_y0) ? a_y0 : b_y0;
      hi_x_in = (a_x1 < b_x1) ? a_x1 : b_x1;
      hi_y_in = (a_y1 < b_y1) ? a_y1 : b_y1;

      dx    = hi_x_ff - lo_x_ff;
      dy    = hi_y_ff - lo_y_ff;
      iw_in = (hi_x_ff > lo_x_ff) ? dx[C-1:0] : '0;
      ih_in = (hi_y_ff > lo_y_ff) ? dy[C-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_x_ff   <= lo_x_in;
      hi_x_ff   <= hi_x_in;
      lo_y_ff   <= lo_y_in;
      hi_y_ff   <= hi_y_in;
      aw1_ff    <= a_w;
      ah1_ff    <= a_h;
      bw1_ff    <= b_w;
      bh1_ff    <= b_h;

      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      aw2_ff    <= aw1_ff;
      ah2_ff    <= ah1_ff;
      bw2_ff    <= bw1_ff;
      bh2_ff    <= bh1_ff;

      inter3_ff <= AREA_W'(iw_ff) * AREA_W'(ih_ff);
      area_a_ff <= AREA_W'(aw2_ff) * AREA_W'(ah2_ff);
      area_b_ff <= AREA_W'(bw2_ff) * AREA_W'(bh2_ff);

      uni_ff    <= UNI_W'(area_a_ff) + UNI_W'(area_b_ff) - UNI_W'(inter3_ff);
      inter4_ff <= inter3_ff;

      prod_ff   <= PROD_W'(thr) * PROD_W'(uni_ff);
      shift_ff  <= {1'b0, inter4_ff, {gbn_pkg::THR_W{1'b0}}};

      // zero union implies zero intersection, so that pair never hits
      hit_ff    <= shift_ff > prod_ff;
   end

   assign status.busy = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff | v6_ff;
   assign status.hit  = v6_ff & hit_ff;

endmodule

### sv/greedy_box_nms.sv
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy non-maximum suppression over score-ordered boxes with a kept box
// store, an overlap compare pipeline and a one-beat result register.
// ----------------------------------------------------------------------------
// each request beat: one store read per box kept so far, then the compare pipeline
// drain, then the result register load; no new request beat is taken before that
// load, but a new request beat is taken while the previous result still waits
// reset: synchronous, clears counts, state and result valid, threshold 29491
// the kept store is not cleared; only entries below the kept count are read
module greedy_box_nms #(
   parameter int MAX_KEPT   = 256,
   parameter int COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_first,
   input  logic signed [COORD_BITS-1:0]       req_box_left,
   input  logic signed [COORD_BITS-1:0]       req_box_top,
   input  logic        [COORD_BITS-1:0]       req_box_width,
   input  logic        [COORD_BITS-1:0]       req_box_height,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_keep,
   output logic [gbn_pkg::ITEM_W-1:0]         rsp_item_number,
   output logic [gbn_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                               rsp_store_full,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gbn_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [gbn_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int BOX_W  = 4 * COORD_BITS;
   localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W  = $clog2(MAX_KEPT + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           kept_count_ff, kept_count_in;
   logic [CNT_W-1:0]           scan_idx_ff, scan_idx_in;
   logic [gbn_pkg::ITEM_W-1:0] item_count_ff, item_count_in;
   logic [gbn_pkg::ITEM_W-1:0] number_ff, number_cur;
   logic                       hit_ff, hit_in;
   logic                       rd_valid_ff;
   logic [BOX_W-1:0]           cur_box_ff;
   logic [gbn_pkg::THR_W-1:0]  thr_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_keep_ff;
   logic [gbn_pkg::ITEM_W-1:0] rsp_item_number_ff;
   logic [gbn_pkg::SLOT_W-1:0] rsp_slot_ff, slot_cur;
   logic                       rsp_store_full_ff;

   logic                       req_accept;
   logic                       rsp_free;
   logic                       resp_load;
   logic                       room;
   logic                       keep;
   logic                       mem_wr;
   logic                       mem_rd;
   logic [CNT_W-1:0]           count_cur;
   logic [CNT_W-1:0]           scan_next;
   logic [CNT_W+gbn_pkg::SLOT_W-1:0] slot_ext;
   logic [BOX_W-1:0]           kept_box;
   logic                       csr_wr;
   gbn_pkg::cmp_status_type    cmp_status;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      prdata = '0;
      if (paddr[2] == gbn_pkg::CSR_IDX_THR) begin
         prdata = {{(gbn_pkg::CSR_DATA_W - gbn_pkg::THR_W){1'b0}}, thr_ff};
      end
   end

   // handshake
   assign req_accept = req_valid & (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;
   assign resp_load  = (state_ff == ST_RESP) & rsp_free;

   assign room     = kept_count_ff < CNT_MAX;
   assign keep     = ~hit_ff;
   assign mem_wr   = resp_load & keep & room;
   assign mem_rd   = (state_ff == ST_SCAN);
   assign slot_ext = {{gbn_pkg::SLOT_W{1'b0}}, kept_count_ff};
   assign slot_cur = (keep & room) ? slot_ext[gbn_pkg::SLOT_W-1:0] : '0;

   always_comb begin
      count_cur  = req_first ? '0 : kept_count_ff;
      number_cur = req_first ? '0 : item_count_ff;
      scan_next  = scan_idx_ff + 1'b1;

      state_in      = state_ff;
      kept_count_in = kept_count_ff;
      scan_idx_in   = scan_idx_ff;
      item_count_in = item_count_ff;
      hit_in        = hit_ff | cmp_status.hit;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kept_count_in = count_cur;
               item_count_in = (number_cur != gbn_pkg::ITEM_MAX) ?
                               number_cur + 1'b1 : number_cur;
               scan_idx_in   = '0;
               hit_in        = 1'b0;
               state_in      = (count_cur == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_next;
            if (scan_next == kept_count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !cmp_status.busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               if (mem_wr) begin
                  kept_count_in = kept_count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      priority if (resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kept_count_ff <= '0;
         scan_idx_ff   <= '0;
         item_count_ff <= '0;
         hit_ff        <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= gbn_pkg::THR_RESET;
      end else begin
         state_ff      <= state_in;
         kept_count_ff <= kept_count_in;
         scan_idx_ff   <= scan_idx_in;
         item_count_ff <= item_count_in;
         hit_ff        <= hit_in;
         rd_valid_ff   <= mem_rd;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr && paddr[2] == gbn_pkg::CSR_IDX_THR) begin
            thr_ff <= pwdata[gbn_pkg::THR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_box_ff <= {req_box_left, req_box_top, req_box_width, req_box_height};
         number_ff  <= number_cur;
      end
      if (resp_load) begin
         rsp_keep_ff        <= keep;
         rsp_item_number_ff <= number_ff;
         rsp_slot_ff        <= slot_cur;
         rsp_store_full_ff  <= keep & ~room;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_keep        = rsp_keep_ff;
   assign rsp_item_number = rsp_item_number_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_store_full  = rsp_store_full_ff;

   gbn_kept_store #(
      .DEPTH  (MAX_KEPT),
      .ADDR_W (ADDR_W),
      .DATA_W (BOX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (kept_count_ff[ADDR_W-1:0]),
      .wr_data (cur_box_ff),
      .rd_en   (mem_rd),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (kept_box)
   );

   gbn_iou_pipe #(
      .COORD_BITS (COORD_BITS)
   ) u_pipe (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .cur_box  (cur_box_ff),
      .kept_box (kept_box),
      .thr      (thr_ff),
      .status   (cmp_status)
   );

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= CNT_MAX)
      else $error("kept count beyond store depth");

   a_store_grows: assert property (@(posedge clock) disable iff (reset)
      mem_wr |=> kept_count_ff == $past(kept_count_ff) + 1'b1)
      else $error("store write without kept count step");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result beat raised outside response step");

   a_cmp_in_work: assert property (@(posedge clock) disable iff (reset)
      cmp_status.hit |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("compare result while no box is in work");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_rd |-> scan_idx_ff < kept_count_ff)
      else $error("read of store entry beyond kept count");

endmodule
